// ----- hdl/psw_pkg.sv -----
package psw_pkg;

	// Width of the pulse timer. The timer saturates at its all-ones value.
	localparam int WIDTH_BITS = 12;

	// Width of the configuration registers and of the reported pulse width.
	localparam int REG_BITS = 12;
	localparam int OUT_BITS = 12;
	localparam int INDEX_BITS = 3;

	localparam logic [WIDTH_BITS-1:0] COUNT_MAX = {WIDTH_BITS{1'b1}};
	localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

	// Decode modes. The unused code behaves as toggle mode.
	localparam logic [1:0] MODE_THREE = 2'd0;
	localparam logic [1:0] MODE_DIRECT = 2'd1;
	localparam logic [1:0] MODE_TOGGLE = 2'd2;

	// Configuration register indexes.
	localparam logic [INDEX_BITS-1:0] REG_MODE = 3'd0;
	localparam logic [INDEX_BITS-1:0] REG_MIN_VALID = 3'd1;
	localparam logic [INDEX_BITS-1:0] REG_LOW_LIMIT = 3'd2;
	localparam logic [INDEX_BITS-1:0] REG_MID_LIMIT = 3'd3;
	localparam logic [INDEX_BITS-1:0] REG_SPLIT = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [REG_BITS-1:0] MIN_VALID_RST = 12'd900;
	localparam logic [REG_BITS-1:0] LOW_LIMIT_RST = 12'd1333;
	localparam logic [REG_BITS-1:0] MID_LIMIT_RST = 12'd1666;
	localparam logic [REG_BITS-1:0] SPLIT_RST = 12'd1550;

	typedef struct packed {
		logic [1:0]          mode;
		logic [REG_BITS-1:0] min_valid;
		logic [REG_BITS-1:0] low_limit;
		logic [REG_BITS-1:0] mid_limit;
		logic [REG_BITS-1:0] split;
	} psw_cfg_t;

endpackage

// ----- hdl/psw_cfg_regs.sv -----
module psw_cfg_regs
	import psw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [INDEX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0]   cfg_data,
	output psw_cfg_t              cfg
);

	psw_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_THREE;
			cfg_q.min_valid <= MIN_VALID_RST;
			cfg_q.low_limit <= LOW_LIMIT_RST;
			cfg_q.mid_limit <= MID_LIMIT_RST;
			cfg_q.split     <= SPLIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:      cfg_q.mode      <= cfg_data[1:0];
				REG_MIN_VALID: cfg_q.min_valid <= cfg_data;
				REG_LOW_LIMIT: cfg_q.low_limit <= cfg_data;
				REG_MID_LIMIT: cfg_q.mid_limit <= cfg_data;
				REG_SPLIT:     cfg_q.split     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/psw_decode.sv -----
module psw_decode
	import psw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                level,
	input  logic                take_in,
	input  psw_cfg_t            cfg,
	output logic [1:0]          position,
	output logic                pending,
	output logic [OUT_BITS-1:0] measured_width
);

	logic [WIDTH_BITS-1:0] cnt_q, cnt_d;
	logic                  start_q, start_d;
	logic                  prev_q;
	logic [1:0]            pos_q, pos_d;
	logic                  pend_q, pend_d;
	logic                  rest_q, rest_d;
	logic                  seen_q, seen_d;
	logic                  first_q, first_d;
	logic [OUT_BITS-1:0]   last_w_q, last_w_d;

	logic                  wide_ok;
	logic                  toggle_lvl;

	always_comb begin
		cnt_d      = cnt_q;
		start_d    = start_q;
		pos_d      = pos_q;
		pend_d     = pend_q & ~take_in;
		rest_d     = rest_q;
		seen_d     = seen_q;
		first_d    = first_q;
		last_w_d   = last_w_q;
		wide_ok    = cnt_q > WIDTH_BITS'(cfg.min_valid);
		toggle_lvl = 1'b0;

		if (level) begin
			if (!prev_q) begin
				cnt_d   = WIDTH_BITS'(1);
				start_d = 1'b1;
			end else if (cnt_q != COUNT_MAX) begin
				cnt_d = cnt_q + WIDTH_BITS'(1);
			end
		end else if (prev_q && start_q && !pend_d) begin
			// Falling edge of a timed pulse with nothing pending: decode it.
			start_d = 1'b0;
			if (cnt_q > WIDTH_BITS'(OUT_MAX)) begin
				last_w_d = OUT_MAX;
			end else begin
				last_w_d = cnt_q[OUT_BITS-1:0];
			end

			case (cfg.mode)
				MODE_THREE: begin
					if (wide_ok) begin
						if (cnt_q <= WIDTH_BITS'(cfg.low_limit)) begin
							pos_d = 2'd0;
						end else if (cnt_q <= WIDTH_BITS'(cfg.mid_limit)) begin
							pos_d = 2'd1;
						end else begin
							pos_d = 2'd2;
						end
						pend_d = 1'b1;
					end
				end
				MODE_DIRECT: begin
					if (wide_ok) begin
						pos_d = (cnt_q < WIDTH_BITS'(cfg.split)) ? 2'd0 : 2'd1;
					end
					// A short pulse keeps the position but still marks it pending.
					pend_d = 1'b1;
				end
				default: begin
					if (wide_ok) begin
						pos_d = (cnt_q < WIDTH_BITS'(cfg.split)) ? 2'd0 : 2'd1;
					end
					toggle_lvl = (pos_d != 2'd0);
					if (first_q) begin
						// The first decoded pulse defines the rest level.
						first_d = 1'b0;
						rest_d  = toggle_lvl;
						seen_d  = toggle_lvl;
					end else begin
						if (seen_q == rest_q && seen_q != toggle_lvl) begin
							pend_d = 1'b1;
						end
						seen_d = toggle_lvl;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			start_q  <= 1'b0;
			prev_q   <= 1'b0;
			pos_q    <= 2'd0;
			pend_q   <= 1'b0;
			rest_q   <= 1'b0;
			seen_q   <= 1'b0;
			first_q  <= 1'b1;
			last_w_q <= '0;
		end else if (step) begin
			cnt_q    <= cnt_d;
			start_q  <= start_d;
			prev_q   <= level;
			pos_q    <= pos_d;
			pend_q   <= pend_d;
			rest_q   <= rest_d;
			seen_q   <= seen_d;
			first_q  <= first_d;
			last_w_q <= last_w_d;
		end
	end

	assign position       = pos_q;
	assign pending        = pend_q;
	assign measured_width = last_w_q;

endmodule

// ----- hdl/rc_pulse_switch_decoder_unit.sv -----
// RC pulse switch decoder. Each input item is one microsecond tick carrying the
// sampled receiver pin level and a take strobe, and each item yields exactly one
// result item: the decoded switch position, the pending flag and the width of the
// last decoded pulse. High pulses are timed with a saturating counter from the
// rising edge; on the falling edge, when no position is pending, the width is
// decoded in three-position, two-position direct or two-position toggle mode.
// The block accepts one item in every cycle unless the result side stalls: the
// item is captured in an input register, and then a single pass of compare and
// select logic updates the decoder state, whose position, pending and width
// registers are the result register. A stalled result holds back only the input
// register, so the input side keeps flowing until both registers are full. The
// user must write configuration registers through the plain write port while the
// block is idle (not enforced by the block); there is no start-up clearing pass.
module rc_pulse_switch_decoder_unit
	import psw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  pin_level,
	input  logic                  take,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            position,
	output logic                  pending,
	output logic [OUT_BITS-1:0]   measured_width,

	input  logic                  cfg_we,
	input  logic [INDEX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0]   cfg_data
);

	psw_cfg_t cfg;

	logic s1_valid;
	logic pin_level_s1;
	logic take_s1;
	logic out_valid_q;
	logic advance;

	// The input register moves into the result stage whenever that stage is empty
	// or its result is being taken in this cycle.
	assign advance  = s1_valid && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!in_stall) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_level_s1 <= pin_level;
			take_s1      <= take;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	psw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The decoder state only moves when an item enters the result stage, so its
	// output registers always hold the result of the newest item.
	psw_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.level          (pin_level_s1),
		.take_in        (take_s1),
		.cfg            (cfg),
		.position       (position),
		.pending        (pending),
		.measured_width (measured_width)
	);

	// The input side stalls only when both stages hold an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid && out_valid_q && out_stall))
		else $error("input stalled while a stage was free");

	// Pending can only be raised when an item enters the result stage. A take on
	// the falling edge clears the old flag first, so that item may raise it again.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending) |-> $past(advance))
		else $error("pending raised without an advancing item");

	// The reported width changes only when an item enters the result stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(measured_width) |-> $past(advance))
		else $error("measured width changed without an item");

	// Position 3 is never decoded.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (position != 2'd3))
		else $error("invalid position code");

endmodule

// ----- bench/rc_pulse_switch_decoder_unit_tb.sv -----
`timescale 1ns / 100ps

module rc_pulse_switch_decoder_unit_tb;
	import psw_pkg::*;

	// The spare mode code behaves as toggle mode. Index seven maps to no register.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [INDEX_BITS-1:0] UNMAPPED_INDEX = 3'd7;

	// Cap on the run.
	localparam int CYCLE_LIMIT = 2000000;
	localparam int LONG_HOLD_CYCLES = 300;

	// One input item is one microsecond tick of the receiver pin.
	typedef struct packed {
		logic lvl;
		logic tk;
	} pin_tick_t;

	// One result item: the decoder state after the tick.
	typedef struct packed {
		logic [1:0]          pos;
		logic                pend;
		logic [OUT_BITS-1:0] width;
	} switch_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic pin_level = 1'b0;
	logic take = 1'b0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] position;
	logic pending;
	logic [OUT_BITS-1:0] measured_width;

	logic cfg_we = 1'b0;
	logic [INDEX_BITS-1:0] cfg_index = '0;
	logic [REG_BITS-1:0] cfg_data = '0;

	// Ticks waiting to be offered, and the switch results they are known to produce.
	pin_tick_t tick_q[$];
	switch_result_t expected_switch_q[$];

	// The decoder setting as the testbench believes it to be.
	logic [1:0] cur_mode = MODE_THREE;
	logic [REG_BITS-1:0] cur_min = MIN_VALID_RST;
	logic [REG_BITS-1:0] cur_low = LOW_LIMIT_RST;
	logic [REG_BITS-1:0] cur_mid = MID_LIMIT_RST;
	logic [REG_BITS-1:0] cur_split = SPLIT_RST;

	// The decoder state as the testbench tracks it, starting from its reset values.
	logic [WIDTH_BITS-1:0] pulse_count = '0;
	logic timing = 1'b0;
	logic last_lvl = 1'b0;
	logic [1:0] pos_q = 2'd0;
	logic pend_q = 1'b0;
	logic rest_lvl = 1'b0;
	logic seen_lvl = 1'b0;
	logic awaiting_first = 1'b1;
	logic [OUT_BITS-1:0] width_out = '0;

	// When set, neither side idles, so long pulses pass quickly and back-to-back flow
	// gets its own stretches.
	bit steady_flow = 1'b0;
	int long_hold_asked = 0;
	int long_hold_served = 0;

	int fail_count = 0;
	int ticks_sent = 0;
	int results_checked = 0;
	int decodes_done = 0;
	int cycle_count = 0;

	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	pin_tick_t next_tick;
	switch_result_t oldest_result;

	rc_pulse_switch_decoder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pin_level      (pin_level),
		.take           (take),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.position       (position),
		.pending        (pending),
		.measured_width (measured_width),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pause_cycles();
		if (steady_flow)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	// Decode a finished pulse of width w into position, pending and the reported width.
	task automatic classify_width(input logic [WIDTH_BITS-1:0] w);
		logic long_enough;
		logic lvl;
		long_enough = w > cur_min;
		width_out = (w > OUT_MAX) ? OUT_MAX : w[OUT_BITS-1:0];
		if (cur_mode == MODE_THREE) begin
			if (long_enough) begin
				if (w <= cur_low)
					pos_q = 2'd0;
				else if (w <= cur_mid)
					pos_q = 2'd1;
				else
					pos_q = 2'd2;
				pend_q = 1'b1;
			end
		end else begin
			if (long_enough)
				pos_q = (w < cur_split) ? 2'd0 : 2'd1;
			if (cur_mode == MODE_DIRECT) begin
				// A short pulse keeps the old position but still raises pending.
				pend_q = 1'b1;
			end else begin
				// Toggle: any nonzero position, a leftover 2 included, reads as level 1.
				lvl = (pos_q != 2'd0);
				if (awaiting_first) begin
					awaiting_first = 1'b0;
					rest_lvl = lvl;
					seen_lvl = lvl;
				end else begin
					if (seen_lvl == rest_lvl && seen_lvl != lvl)
						pend_q = 1'b1;
					seen_lvl = lvl;
				end
			end
		end
		decodes_done++;
	endtask

	// Advance the tracked state by one accepted tick and queue the result it produces.
	// The take strobe acts before the edge, so a pulse that ends on a take is decoded.
	task automatic predict_switch(input pin_tick_t t);
		switch_result_t r;
		if (t.tk)
			pend_q = 1'b0;
		if (t.lvl) begin
			if (!last_lvl) begin
				pulse_count = WIDTH_BITS'(1);
				timing = 1'b1;
			end else if (pulse_count != COUNT_MAX) begin
				pulse_count = pulse_count + 1'b1;
			end
		end else if (last_lvl && timing && !pend_q) begin
			// A falling edge while a position is pending is ignored and the timing
			// stays marked as running until the next rising edge restarts it.
			classify_width(pulse_count);
			timing = 1'b0;
		end
		last_lvl = t.lvl;
		r.pos = pos_q;
		r.pend = pend_q;
		r.width = width_out;
		expected_switch_q.push_back(r);
	endtask

	// The sender. An accepted item is predicted at once, then the next item is put up
	// after a random number of idle cycles. A stalled item stays on the port unchanged.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pin_level <= 1'b0;
			take <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_switch('{pin_level, take});
				ticks_sent++;
				gap_left = pause_cycles();
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					next_tick = tick_q.pop_front();
					in_valid <= 1'b1;
					pin_level <= next_tick.lvl;
					take <= next_tick.tk;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The receiver. Every accepted result is checked against the oldest expectation.
	// It stalls a random number of cycles after each result, and on request holds off
	// for a long stretch so the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_switch_q.size() == 0) begin
					$error("result with no item behind it: position %0d pending %0d width %0d",
						position, pending, measured_width);
					fail_count++;
				end else begin
					oldest_result = expected_switch_q.pop_front();
					if (position !== oldest_result.pos) begin
						$error("position: expected %0d, actual %0d", oldest_result.pos, position);
						fail_count++;
					end
					if (pending !== oldest_result.pend) begin
						$error("pending: expected %0d, actual %0d", oldest_result.pend, pending);
						fail_count++;
					end
					if (measured_width !== oldest_result.width) begin
						$error("measured_width: expected %0d, actual %0d",
							oldest_result.width, measured_width);
						fail_count++;
					end
					results_checked++;
				end
				stall_left = pause_cycles();
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (long_hold_served != long_hold_asked) begin
				long_hold_served++;
				hold_left = LONG_HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, expected_switch_q.size());
			$display("rc_pulse_switch_decoder_unit_tb: errors");
			$finish;
		end
	end

	task automatic push_tick(input logic lvl, input logic tk);
		tick_q.push_back('{lvl, tk});
	endtask

	// A high pulse of high_len ticks followed by low_len low ticks; the first low tick,
	// which is the falling edge, may carry a take.
	task automatic queue_pulse(input int high_len, input int low_len, input logic take_on_fall);
		int k;
		for (k = 0; k < high_len; k++)
			push_tick(1'b1, 1'b0);
		push_tick(1'b0, take_on_fall);
		for (k = 1; k < low_len; k++)
			push_tick(1'b0, 1'b0);
	endtask

	// Mostly well-formed pulses with random widths and scattered takes, with a tenth
	// of the bursts being raw noise on both bits.
	task automatic queue_random_ticks(input int count, input int max_high);
		int added;
		int len;
		int k;
		int choice;
		added = 0;
		while (added < count) begin
			choice = $urandom_range(0, 9);
			if (choice == 0) begin
				len = $urandom_range(1, 6);
				for (k = 0; k < len; k++)
					push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				added += len;
			end else begin
				len = $urandom_range(1, 4);
				for (k = 0; k < len; k++)
					push_tick(1'b0, $urandom_range(0, 5) == 0);
				added += len;
				len = $urandom_range(1, max_high);
				for (k = 0; k < len; k++)
					push_tick(1'b1, $urandom_range(0, 7) == 0);
				added += len;
			end
		end
	endtask

	// Wait until every queued item has gone in and every result has come out, then let
	// the pipeline settle.
	task automatic drain();
		while (tick_q.size() != 0 || in_valid || expected_switch_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write through the plain port; the tracked setting follows the write.
	task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE: cur_mode = val[1:0];
			REG_MIN_VALID: cur_min = val;
			REG_LOW_LIMIT: cur_low = val;
			REG_MID_LIMIT: cur_mid = val;
			REG_SPLIT: cur_split = val;
			default: ;
		endcase
	endtask

	// The mode register only keeps its low two bits, so the upper bits carry noise.
	task automatic write_mode(input logic [1:0] mode);
		write_reg(REG_MODE, {REG_BITS'($urandom_range(0, 1023)) << 2} | REG_BITS'(mode));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks at the reset setting: three-position mode with the stock limits.
		// A take with nothing pending and short pulses, one ending on a take, that only
		// update the reported width.
		steady_flow = 1'b1;
		push_tick(1'b0, 1'b1);
		queue_pulse(3, 2, 1'b0);
		queue_pulse(12, 2, 1'b1);
		push_tick(1'b0, 1'b1);
		drain();

		// Three-position mode with small limits. The receiver holds off early on while
		// the sender keeps offering, so the block fills up and stalls its input. The
		// phase ends on a wide pulse that leaves position 2 behind, and the pending
		// position is then taken.
		write_mode(MODE_THREE);
		write_reg(REG_MIN_VALID, 12'd3);
		write_reg(REG_LOW_LIMIT, 12'd6);
		write_reg(REG_MID_LIMIT, 12'd10);
		steady_flow = 1'b0;
		long_hold_asked++;
		queue_random_ticks(130, 14);
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		queue_pulse(14, 2, 1'b0);
		push_tick(1'b0, 1'b1);
		drain();

		// Toggle mode. Its first decode is a short pulse, so the leftover position 2
		// becomes the rest level.
		write_mode(MODE_TOGGLE);
		write_reg(REG_MIN_VALID, 12'd2);
		write_reg(REG_SPLIT, 12'd7);
		queue_pulse(1, 2, 1'b0);
		queue_random_ticks(130, 12);
		drain();

		// Two-position direct mode.
		write_mode(MODE_DIRECT);
		write_reg(REG_MIN_VALID, 12'd4);
		write_reg(REG_SPLIT, 12'd9);
		queue_random_ticks(130, 14);
		drain();

		// The spare mode code, plus a write to an index that maps to no register.
		write_mode(MODE_SPARE);
		write_reg(REG_MIN_VALID, 12'd5);
		write_reg(REG_SPLIT, 12'd11);
		write_reg(UNMAPPED_INDEX, 12'hABC);
		queue_random_ticks(100, 16);
		drain();

		// Extremes in three-position mode: every width above zero is valid, first
		// landing in the middle band, then always above the middle limit.
		write_mode(MODE_THREE);
		write_reg(REG_MIN_VALID, 12'd0);
		write_reg(REG_LOW_LIMIT, 12'd0);
		write_reg(REG_MID_LIMIT, 12'd4095);
		queue_random_ticks(60, 6);
		drain();
		write_reg(REG_MID_LIMIT, 12'd0);
		queue_random_ticks(40, 6);
		drain();

		// Direct mode with a zero split: every decode gives position 1.
		write_mode(MODE_DIRECT);
		write_reg(REG_SPLIT, 12'd0);
		queue_random_ticks(50, 6);
		drain();

		// Direct mode at the top of the range: no width can pass the minimum, so the
		// position stays put while every decode still raises pending.
		steady_flow = 1'b1;
		write_reg(REG_MIN_VALID, 12'd4095);
		write_reg(REG_SPLIT, 12'd4095);
		queue_pulse(10, 2, 1'b0);
		push_tick(1'b0, 1'b1);
		drain();
		steady_flow = 1'b0;
		queue_random_ticks(50, 8);
		drain();

		// Toggle mode again with random idling, now long past its first pulse.
		write_mode(MODE_TOGGLE);
		write_reg(REG_MIN_VALID, 12'd3);
		write_reg(REG_SPLIT, 12'd6);
		queue_random_ticks(150, 10);
		drain();

		// Three-position mode with no idling on either side.
		write_mode(MODE_THREE);
		write_reg(REG_MIN_VALID, 12'd1);
		write_reg(REG_LOW_LIMIT, 12'd4);
		write_reg(REG_MID_LIMIT, 12'd8);
		steady_flow = 1'b1;
		queue_random_ticks(100, 12);
		drain();
		repeat (8) @(posedge clk);

		if (expected_switch_q.size() != 0) begin
			$error("%0d results never arrived", expected_switch_q.size());
			fail_count++;
		end
		$display("Covered all four decode mode codes, register extremes, takes on edges");
		$display("and stalls on both sides, including a long receiver hold-off.");
		$display("%0d pin ticks sent, %0d results checked, %0d pulses decoded, %0d failures.",
			ticks_sent, results_checked, decodes_done, fail_count);
		if (fail_count == 0)
			$display("rc_pulse_switch_decoder_unit_tb: clean");
		else
			$display("rc_pulse_switch_decoder_unit_tb: errors");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/psw_pkg.sv
hdl/psw_cfg_regs.sv
hdl/psw_decode.sv
hdl/rc_pulse_switch_decoder_unit.sv
bench/rc_pulse_switch_decoder_unit_tb.sv
